[design/kpms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpms_pkg
// Shared types, widths and key ordering for the k-way merge select core.
// ----------------------------------------------------------------------------
package kpms_pkg;

  localparam int MAX_SOURCES = 16;
  localparam int POS_W       = 32;
  localparam int SRC_W       = $clog2(MAX_SOURCES);
  localparam int CFG_W       = 5;
  localparam int CNT_W       = $clog2(MAX_SOURCES + 1);

  // one stream's next key
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    strand;
    logic                    exhausted;
  } key_t;

  // running best handed along the cell row
  typedef struct packed {
    logic [SRC_W-1:0] idx;
    key_t             key;
  } best_t;

  // input word
  typedef struct packed {
    logic [SRC_W-1:0]        source_id;
    logic signed [POS_W-1:0] position;
    logic                    strand;
    logic                    exhausted;
  } in_t;

  // result word
  typedef struct packed {
    logic [SRC_W-1:0]        winner_source;
    logic signed [POS_W-1:0] winner_position;
    logic                    winner_strand;
    logic                    all_done;
    logic                    order_error;
  } out_t;

  // true when key a strictly precedes key b
  function automatic logic key_before(input key_t a, input key_t b);
    logic res;
    if (a.exhausted) begin
      res = 1'b0;
    end else if (b.exhausted) begin
      res = 1'b1;
    end else if (a.position != b.position) begin
      res = ($signed(a.position) < $signed(b.position));
    end else begin
      res = (a.strand < b.strand);
    end
    return res;
  endfunction

endpackage

[design/kway_position_merge_select_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_position_merge_select_core
// Picks the next record of a k-way merge: a row of key cells passes the
// running minimum one cell per cycle, and the winner is held for its refill.
// ----------------------------------------------------------------------------
// A refill's result is in the output register in the cycle after accept.
// Reselection walks the cell row after the word that ends priming or a correct
// refill; in_stall stays high until it is done, so no word is taken meanwhile.
// Priming words that do not end priming and wrong-source words start no reselection.
// Reset (synchronous, active low): all slots empty, counts and winner zero,
// num_sources = 1.
// ----------------------------------------------------------------------------
module kway_position_merge_select_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [kpms_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  kpms_pkg::in_t                  in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output kpms_pkg::out_t                 out_word
);
  import kpms_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] num_sources_r;
  logic [CNT_W-1:0] active_n;
  logic [CNT_W-1:0] primed_cnt_r, primed_cnt_nxt;
  logic [CNT_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic [SRC_W-1:0] pending_winner_r, pending_winner_nxt;
  logic             out_valid_r;
  out_t             out_word_r;

  logic             acc;
  logic             priming;
  logic             hit;
  logic             start_scan;
  logic             load_out;
  key_t             wr_key;
  key_t             wkey;
  out_t             res;
  best_t            chain [MAX_SOURCES+1];
  key_t             cell_key [MAX_SOURCES];

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_sources_r <= CFG_W'(1);
    end else if (cfg_we) begin
      num_sources_r <= cfg_wdata;
    end
  end

  // clamp the stream count into 1..MAX_SOURCES
  always_comb begin
    if (num_sources_r == '0) begin
      active_n = CNT_W'(1);
    end else if (CNT_W'(num_sources_r) > CNT_W'(MAX_SOURCES)) begin
      active_n = CNT_W'(MAX_SOURCES);
    end else begin
      active_n = CNT_W'(num_sources_r);
    end
  end

  // handshake and decode
  assign priming  = (primed_cnt_r < active_n);
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall && !priming);
  assign acc      = in_valid && !in_stall;
  assign hit      = (in_word.source_id == pending_winner_r);
  assign load_out = acc && !priming;
  assign start_scan = acc && ((priming && ((primed_cnt_r + CNT_W'(1)) >= active_n)) ||
                              (!priming && hit));

  assign wr_key = '{position: in_word.position, strand: in_word.strand,
                    exhausted: in_word.exhausted};

  // the row of key cells
  assign chain[0] = '{idx: '0, key: '{position: '0, strand: 1'b0, exhausted: 1'b1}};

  for (genvar i = 0; i < MAX_SOURCES; i++) begin : g_cell
    kpms_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SRC_W'(i)),
      .wr_en    (acc && (priming || hit) && (in_word.source_id == SRC_W'(i))),
      .wr_key   (wr_key),
      .active   (CNT_W'(i) < active_n),
      .best_in  (chain[i]),
      .best_out (chain[i+1]),
      .key_out  (cell_key[i])
    );
  end

  // result from the winner's key before its refill
  assign wkey = cell_key[pending_winner_r];

  always_comb begin
    res = '0;
    if (!hit) begin
      res.order_error = 1'b1;
    end else begin
      res.winner_source = pending_winner_r;
      if (wkey.exhausted) begin
        res.all_done = 1'b1;
      end else begin
        res.winner_position = wkey.position;
        res.winner_strand   = wkey.strand;
      end
    end
  end

  // control sequencing
  always_comb begin
    state_nxt          = state_r;
    scan_cnt_nxt       = scan_cnt_r;
    pending_winner_nxt = pending_winner_r;
    primed_cnt_nxt     = primed_cnt_r;
    if (acc && priming) begin
      primed_cnt_nxt = primed_cnt_r + CNT_W'(1);
    end
    unique case (state_r)
      ST_IDLE: begin
        if (start_scan) begin
          state_nxt    = ST_SCAN;
          scan_cnt_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == CNT_W'(MAX_SOURCES)) begin
          pending_winner_nxt = chain[MAX_SOURCES].idx;
          state_nxt          = ST_IDLE;
        end else begin
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      scan_cnt_r       <= '0;
      pending_winner_r <= '0;
      primed_cnt_r     <= '0;
    end else begin
      state_r          <= state_nxt;
      scan_cnt_r       <= scan_cnt_nxt;
      pending_winner_r <= pending_winner_nxt;
      primed_cnt_r     <= primed_cnt_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // checks
  a_out_from_refill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(acc && !priming))
    else $error("result appeared without a refill word");

  a_refill_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !priming && hit) |=> (state_r == ST_SCAN) && (scan_cnt_r == '0))
    else $error("correct refill did not start reselection");

  a_winner_stable_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && $past(state_r == ST_SCAN) |-> $stable(pending_winner_r))
    else $error("pending winner changed during reselection");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_cnt_r <= CNT_W'(MAX_SOURCES)))
    else $error("scan counter ran past the cell row");

endmodule

[design/kpms_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpms_cell
// One key slot of the selection row: holds a stream's key and compares it
// against the running best handed in from the previous cell.
// ----------------------------------------------------------------------------
module kpms_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [kpms_pkg::SRC_W-1:0] cell_idx,
  input  logic                   wr_en,
  input  kpms_pkg::key_t         wr_key,
  input  logic                   active,
  input  kpms_pkg::best_t        best_in,
  output kpms_pkg::best_t        best_out,
  output kpms_pkg::key_t         key_out
);
  import kpms_pkg::*;

  logic signed [POS_W-1:0] pos_r;
  logic                    strand_r;
  logic                    exh_r;
  key_t                    own_key;
  logic                    takes_lead;
  best_t                   best_nxt;
  best_t                   best_r;

  // slot marked empty at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exh_r <= 1'b1;
    end else if (wr_en) begin
      exh_r <= wr_key.exhausted;
    end
  end

  // key payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_r    <= wr_key.position;
      strand_r <= wr_key.strand;
    end
  end

  assign own_key = '{position: pos_r, strand: strand_r, exhausted: exh_r};

  // strictly smaller key takes over, ties stay with the lower index
  assign takes_lead = active && key_before(own_key, best_in.key);

  always_comb begin
    if (takes_lead) begin
      best_nxt = '{idx: cell_idx, key: own_key};
    end else begin
      best_nxt = best_in;
    end
  end

  // hand the best so far to the next cell
  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

  assign best_out = best_r;
  assign key_out  = own_key;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the k-way merge select core. A queue of pending
// words feeds a clocked driver; a clocked monitor compares each result word
// against a running prediction of the key table, the priming count and the
// pending winner. Runs directed priming and refill cases, then random merge
// traffic under several source counts, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import kpms_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_PRINTS    = 30;

  // one queued input word with the result it should cause
  typedef struct {
    in_t  word;
    bit   has_res;
    out_t res;
  } stim_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_t               in_word   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_word;

  kway_position_merge_select_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #1 clk = ~clk;

  // predicted merge state
  logic signed [POS_W-1:0] key_pos  [MAX_SOURCES];
  bit                      key_str  [MAX_SOURCES];
  bit                      key_dead [MAX_SOURCES];
  int unsigned             primed_words;
  logic [SRC_W-1:0]        head_src;
  logic [CFG_W-1:0]        src_count_reg;

  // bench bookkeeping
  stim_t word_backlog[$];
  out_t  expected_records[$];
  stim_t cur;
  out_t  want;
  bit    in_taken   = 1'b0;
  bit    idle_on    = 1'b1;
  int    issued_cnt = 0;
  int    taken_cnt  = 0;
  int    n_results  = 0;
  int    n_order    = 0;
  int    n_done     = 0;
  int    mismatches = 0;
  int    cycle_cnt  = 0;
  int    hold_asks  = 0;
  int    hold_served = 0;
  int    hold_left  = 0;
  int    send_gap   = 0;
  int    stall_burst = 0;

  // effective source count after clamping the register
  function automatic int active_count();
    int n;
    n = int'(src_count_reg);
    if (n < 1) n = 1;
    if (n > MAX_SOURCES) n = MAX_SOURCES;
    return n;
  endfunction

  // slot a strictly ahead of slot b in merge order
  function automatic bit key_precedes(int a, int b);
    bit r;
    if (key_dead[a]) begin
      r = 1'b0;
    end else if (key_dead[b]) begin
      r = 1'b1;
    end else if (key_pos[a] != key_pos[b]) begin
      r = key_pos[a] < key_pos[b];
    end else begin
      r = key_str[a] < key_str[b];
    end
    return r;
  endfunction

  function automatic void pick_winner();
    int best;
    best = 0;
    for (int i = 1; i < active_count(); i++) begin
      if (key_precedes(i, best)) best = i;
    end
    head_src = best[SRC_W-1:0];
  endfunction

  // advance the prediction by one word, return the record it emits
  function automatic void predict_merge(input in_t w, output bit has, output out_t r);
    r   = '0;
    has = 1'b0;
    if (primed_words < active_count()) begin
      key_pos[w.source_id]  = w.position;
      key_str[w.source_id]  = w.strand;
      key_dead[w.source_id] = w.exhausted;
      primed_words = (primed_words + 1) & 5'h1f;
      if (primed_words >= active_count()) pick_winner();
    end else begin
      has = 1'b1;
      if (w.source_id != head_src) begin
        r.order_error = 1'b1;
      end else begin
        r.winner_source = head_src;
        if (key_dead[head_src]) begin
          r.all_done = 1'b1;
        end else begin
          r.winner_position = key_pos[head_src];
          r.winner_strand   = key_str[head_src];
        end
        key_pos[head_src]  = w.position;
        key_str[head_src]  = w.strand;
        key_dead[head_src] = w.exhausted;
        pick_winner();
      end
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
    if (mismatches < MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s expected %0h got %0h",
               cycle_cnt, what, exp_v, got_v);
    end
    mismatches++;
  endtask

  task automatic add_item(input int src, input logic signed [POS_W-1:0] pos,
                          input bit strand, input bit exh);
    stim_t s;
    s.word.source_id = src[SRC_W-1:0];
    s.word.position  = pos;
    s.word.strand    = strand;
    s.word.exhausted = exh;
    predict_merge(s.word, s.has_res, s.res);
    word_backlog.push_back(s);
    issued_cnt++;
  endtask

  // wait until every word is taken and every record has come back
  task automatic drain();
    while (taken_cnt != issued_cnt || expected_records.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_sources(input logic [CFG_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    src_count_reg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well formed merge traffic: prime in order, then refill the winner
  task automatic add_random_items(input int count, input int exh_pct);
    int src;
    int pick;
    longint p;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (primed_words < active_count()) begin
        src = (pick < 12) ? $urandom_range(0, MAX_SOURCES - 1) : primed_words;
      end else if (pick < 8) begin
        src = (head_src + $urandom_range(1, MAX_SOURCES - 1)) % MAX_SOURCES;
      end else if (pick < 11) begin
        src = $urandom_range(0, MAX_SOURCES - 1);
      end else begin
        src = head_src;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60 && !key_dead[src]) begin
        p = longint'(key_pos[src]) + longint'($urandom_range(0, 3));
        if (p > 64'sh7fffffff) p = longint'(key_pos[src]);
      end else if (pick < 85) begin
        p = longint'($urandom_range(0, 30));
      end else if (pick < 95) begin
        p = longint'($urandom & 32'h7fffffff);
      end else begin
        p = -1;
      end
      add_item(src, p[POS_W-1:0], 1'($urandom_range(0, 1)),
               $urandom_range(0, 99) < exh_pct);
    end
  endtask

  // input accept and result check
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      taken_cnt++;
      if (cur.has_res) expected_records.push_back(cur.res);
    end
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_records.size() == 0) begin
        flag_mismatch("result word with nothing pending", 64'(0), 64'(out_word));
      end else begin
        want = expected_records.pop_front();
        if (want.order_error) n_order++;
        if (want.all_done) n_done++;
        if (out_word.winner_source !== want.winner_source)
          flag_mismatch("winner_source", 64'(want.winner_source),
                        64'(out_word.winner_source));
        if (out_word.winner_position !== want.winner_position)
          flag_mismatch("winner_position", 64'(want.winner_position),
                        64'(out_word.winner_position));
        if (out_word.winner_strand !== want.winner_strand)
          flag_mismatch("winner_strand", 64'(want.winner_strand),
                        64'(out_word.winner_strand));
        if (out_word.all_done !== want.all_done)
          flag_mismatch("all_done", 64'(want.all_done), 64'(out_word.all_done));
        if (out_word.order_error !== want.order_error)
          flag_mismatch("order_error", 64'(want.order_error), 64'(out_word.order_error));
      end
    end
  end

  // input driver with random gaps
  always @(negedge clk) begin
    bit nxt_valid;
    nxt_valid = in_valid;
    if (in_valid && in_taken) nxt_valid = 1'b0;
    if (rst_n && !nxt_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (idle_on && word_backlog.size() > 0 && $urandom_range(0, 3) == 0) begin
        send_gap = $urandom_range(0, 2);
      end else if (word_backlog.size() > 0) begin
        cur = word_backlog.pop_front();
        nxt_valid = 1'b1;
      end
    end
    in_valid <= nxt_valid;
    in_word  <= cur.word;
  end

  // result stall: long hold on request, otherwise short random bursts
  always @(negedge clk) begin
    bit nxt_stall;
    nxt_stall = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else if (hold_served != hold_asks) begin
      hold_served++;
      hold_left = LONG_HOLD - 1;
      nxt_stall = 1'b1;
    end else if (stall_burst > 0) begin
      stall_burst--;
      nxt_stall = 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_burst = $urandom_range(0, 2);
      nxt_stall = 1'b1;
    end
    out_stall <= nxt_stall;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d records outstanding",
               cycle_cnt, expected_records.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    for (int i = 0; i < MAX_SOURCES; i++) begin
      key_pos[i]  = '0;
      key_str[i]  = 1'b0;
      key_dead[i] = 1'b1;
    end
    primed_words  = 0;
    head_src      = '0;
    src_count_reg = 5'd1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: priming with overwrite, out-of-range slot and a tie
    set_sources(5'd4);
    add_item(2, 100, 1'b1, 1'b0);
    add_item(2, 100, 1'b0, 1'b0);
    add_item(9, -1, 1'b0, 1'b0);
    add_item(0, 100, 1'b0, 1'b0);
    // wrong source, then refills through the extremes down to all done
    add_item(15, 32'sh7fffffff, 1'b1, 1'b1);
    add_item(head_src, -1, 1'b1, 1'b0);
    add_item(head_src, 32'sh7fffffff, 1'b1, 1'b0);
    add_item(head_src, 0, 1'b0, 1'b0);
    add_item(head_src, 0, 1'b1, 1'b1);
    add_item(head_src, 0, 1'b0, 1'b1);
    add_item(head_src, 5, 1'b1, 1'b1);
    add_item(15, -1, 1'b1, 1'b0);
    add_item(head_src, 5, 1'b0, 1'b0);
    add_item(head_src, 7, 1'b0, 1'b0);

    // full width, finishes priming the upper slots
    set_sources(5'd16);
    add_random_items(300, 1);

    // zero clamps to a single stream
    set_sources(5'd0);
    add_random_items(150, 20);

    // above range clamps to all streams; sender pauses halfway
    set_sources(5'd31);
    add_random_items(150, 1);
    drain();
    add_random_items(150, 1);

    // long receiver hold while words keep coming
    set_sources(5'd7);
    add_random_items(100, 1);
    while (issued_cnt - taken_cnt > 10) @(negedge clk);
    hold_asks++;
    add_random_items(300, 1);

    set_sources(5'd1);
    add_random_items(150, 20);

    // closing stretch with no idling
    set_sources(5'd16);
    idle_on = 1'b0;
    add_random_items(350, 1);
    drain();

    $display("covered %0d input words and %0d result words over 7 source counts",
             taken_cnt, n_results);
    $display("order errors %0d, all-done records %0d, mismatches %0d",
             n_order, n_done, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
